// ===== hdl/tsr_pkg.sv =====
// Shared types, constants and helpers for the TCP source port restore block.
// No dependencies; imported by tsr_flow_cell, tcp_source_port_restore and tb.
`default_nettype none
package tsr_pkg;

  localparam int FlowEntries = 16;

  localparam logic [15:0] EthPIp     = 16'h0800;
  localparam logic [7:0]  IpProtoTcp = 8'd6;

  localparam logic [15:0] MinEthLen = 16'd14;
  localparam logic [15:0] MinIpLen  = 16'd34;

  // status codes
  localparam logic [2:0] ST_NOT_IPV4   = 3'd0;
  localparam logic [2:0] ST_NOT_TCP    = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ST_NO_FLOW    = 3'd3;
  localparam logic [2:0] ST_PORT_MISS  = 3'd4;
  localparam logic [2:0] ST_REWRITTEN  = 3'd5;
  localparam logic [2:0] ST_ENTRY_WR   = 3'd6;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [15:0] orig;
    logic [15:0] redir;
  } tok_t;

  // entry write bundle broadcast to all cells
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] orig;
    logic [15:0] redir;
  } entry_t;

  // one's-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tsr_flow_cell.sv =====
// One flow table slot plus one stage of the lookup chain.
// Depends on tsr_pkg (tok_t, entry_t).
`default_nettype none
module tsr_flow_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire tsr_pkg::entry_t wr_entry_i,
  input  wire logic [31:0]    dip_i,
  input  wire tsr_pkg::tok_t  tok_i,
  output tsr_pkg::tok_t       tok_o
);
  import tsr_pkg::*;

  entry_t entry_q, entry_d;
  tok_t   tok_q, tok_d;

  always_comb begin
    entry_d = entry_q;
    if (wr_en_i) begin
      entry_d = wr_entry_i;
    end
  end

  // an earlier hit passes through untouched, so the lowest index wins
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && entry_q.valid && (entry_q.key == dip_i)) begin
      tok_d.hit   = 1'b1;
      tok_d.orig  = entry_q.orig;
      tok_d.redir = entry_q.redir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      tok_q   <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ===== hdl/tcp_source_port_restore.sv =====
// Top level: header checks, flow lookup chain and port/checksum rewrite.
// Depends on tsr_pkg and tsr_flow_cell.
// Table writes and items rejected by the header checks pass through the early flag register
// and then the output register; lookups pass through the launch register, one register per
// cell and the output register. One item in flight; the next beat is taken once the result
// has left the output register.
// Reset clears every flow entry (valid bits, keys, ports) and all control state.
`default_nettype none
module tcp_source_port_restore (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] ether_type_i,
  input  wire logic [7:0]  ip_protocol_i,
  input  wire logic [3:0]  ip_header_words_i,
  input  wire logic [15:0] frame_length_i,
  input  wire logic [31:0] dest_ip_i,
  input  wire logic [15:0] tcp_source_port_i,
  input  wire logic [15:0] tcp_checksum_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic        entry_valid_i,
  input  wire logic [15:0] entry_original_port_i,
  input  wire logic [15:0] entry_redirected_port_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      source_port_out_o,
  output logic [15:0]      checksum_out_o
);
  import tsr_pkg::*;

  logic accept;
  logic busy_q, busy_d;
  logic early_q, early_d;
  logic launch_q, launch_d;
  logic [2:0]  early_st_q, early_st_d;
  logic [31:0] dip_q;
  logic [15:0] sport_q, csum_q;

  logic out_vld_q, out_vld_d;
  logic [2:0]  out_st_q, out_st_d;
  logic [15:0] out_port_q, out_port_d;
  logic [15:0] out_csum_q, out_csum_d;

  entry_t entry_wr;
  tok_t   tok [FlowEntries+1];
  logic [FlowEntries-1:0] wr_en;

  logic        chk_fail;
  logic [2:0]  chk_st;
  logic [16:0] ip_min_len;
  logic        done;
  logic [15:0] csum_acc0, csum_acc1;

  assign in_stall_o = busy_q | out_vld_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // header checks in the order the protocol layers are parsed
  assign ip_min_len = {1'b0, MinIpLen} + {11'd0, ip_header_words_i, 2'b00};
  always_comb begin
    chk_fail = 1'b1;
    chk_st   = ST_TOO_SHORT;
    if (frame_length_i < MinEthLen) begin
      chk_st = ST_TOO_SHORT;
    end else if (ether_type_i != EthPIp) begin
      chk_st = ST_NOT_IPV4;
    end else if (frame_length_i < MinIpLen) begin
      chk_st = ST_TOO_SHORT;
    end else if (ip_protocol_i != IpProtoTcp) begin
      chk_st = ST_NOT_TCP;
    end else if ({1'b0, frame_length_i} < ip_min_len) begin
      chk_st = ST_TOO_SHORT;
    end else begin
      chk_fail = 1'b0;
    end
  end

  assign entry_wr.valid = entry_valid_i;
  assign entry_wr.key   = dest_ip_i;
  assign entry_wr.orig  = entry_original_port_i;
  assign entry_wr.redir = entry_redirected_port_i;

  assign tok[0] = '{vld: launch_q, hit: 1'b0, orig: 16'd0, redir: 16'd0};

  for (genvar i = 0; i < FlowEntries; i++) begin : g_cell
    assign wr_en[i] = accept & mode_i & (32'(entry_index_i) == i);
    tsr_flow_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[i]),
      .wr_entry_i (entry_wr),
      .dip_i      (dip_q),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  always_comb begin
    busy_d     = busy_q;
    early_d    = 1'b0;
    launch_d   = 1'b0;
    early_st_d = early_st_q;
    if (accept) begin
      busy_d = 1'b1;
      if (mode_i) begin
        early_d    = 1'b1;
        early_st_d = ST_ENTRY_WR;
      end else if (chk_fail) begin
        early_d    = 1'b1;
        early_st_d = chk_st;
      end else begin
        launch_d = 1'b1;
      end
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  // incremental update: HC' = ~(~HC + ~m + m')
  assign csum_acc0 = oc_add16(~csum_q, ~sport_q);
  assign csum_acc1 = oc_add16(csum_acc0, tok[FlowEntries].orig);

  assign done = early_q | tok[FlowEntries].vld;

  always_comb begin
    out_vld_d  = out_vld_q & out_stall_i;
    out_st_d   = out_st_q;
    out_port_d = out_port_q;
    out_csum_d = out_csum_q;
    if (done) begin
      out_vld_d  = 1'b1;
      out_port_d = sport_q;
      out_csum_d = csum_q;
      if (early_q) begin
        out_st_d = early_st_q;
      end else if (!tok[FlowEntries].hit) begin
        out_st_d = ST_NO_FLOW;
      end else if (tok[FlowEntries].redir != sport_q) begin
        out_st_d = ST_PORT_MISS;
      end else begin
        out_st_d   = ST_REWRITTEN;
        out_port_d = tok[FlowEntries].orig;
        out_csum_d = ~csum_acc1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      early_q   <= 1'b0;
      launch_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      early_q   <= early_d;
      launch_q  <= launch_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    early_st_q <= early_st_d;
    out_st_q   <= out_st_d;
    out_port_q <= out_port_d;
    out_csum_q <= out_csum_d;
    if (accept) begin
      dip_q   <= dest_ip_i;
      sport_q <= tcp_source_port_i;
      csum_q  <= tcp_checksum_i;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = out_st_q;
  assign source_port_out_o = out_port_q;
  assign checksum_out_o    = out_csum_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for tcp_source_port_restore: header checks, flow table writes,
// lookup and incremental checksum rewrite, each beat checked by predictor or typed row.
// Depends on tsr_pkg and the tcp_source_port_restore RTL.
`default_nettype none
module tb;
  import tsr_pkg::*;

  localparam int IdlePct     = 28;
  localparam int RandomItems = 600;
  localparam int CycleLimit  = 400000;
  localparam int PrintCap    = 50;

  typedef struct packed {
    logic        mode;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [15:0] frame_length;
    logic [31:0] dest_ip;
    logic [15:0] tcp_source_port;
    logic [15:0] tcp_checksum;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [15:0] entry_original_port;
    logic [15:0] entry_redirected_port;
  } hdr_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] source_port;
    logic [15:0] checksum;
  } hdr_result_t;

  typedef struct packed {
    hdr_item_t   item;
    logic        typed;
    hdr_result_t res;
  } dir_row_t;

  localparam logic [31:0] HostA = 32'hC0A8_0001;
  localparam logic [31:0] HostB = 32'hC0A8_0002;

  // columns: mode, ether_type, protocol, ihl, frame_length, dest_ip, sport, csum,
  //          entry index, entry valid, original port, redirected port
  localparam dir_row_t DirRows [24] = '{
    // table empty after reset: zero key must not match
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd60, 32'h0, 16'h1234, 16'h5678,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NO_FLOW, 16'h1234, 16'h5678}},
    '{'{1'b0, 16'hFFFF, 8'hFF, 4'hF, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_TOO_SHORT, 16'hFFFF, 16'hFFFF}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd13, HostA, 16'h0001, 16'h0002,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_TOO_SHORT, 16'h0001, 16'h0002}},
    '{'{1'b0, 16'h86DD, IpProtoTcp, 4'd5, 16'd14, HostA, 16'h0003, 16'h0004,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NOT_IPV4, 16'h0003, 16'h0004}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd0, 16'd14, HostA, 16'h0005, 16'h0006,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_TOO_SHORT, 16'h0005, 16'h0006}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd0, 16'd33, HostA, 16'h0007, 16'h0008,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_TOO_SHORT, 16'h0007, 16'h0008}},
    '{'{1'b0, EthPIp, 8'h11, 4'd5, 16'd34, HostA, 16'h0009, 16'h000A,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NOT_TCP, 16'h0009, 16'h000A}},
    // IHL of zero is not rejected
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd0, 16'd34, HostA, 16'h000B, 16'h000C,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NO_FLOW, 16'h000B, 16'h000C}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd53, HostA, 16'h000D, 16'h000E,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_TOO_SHORT, 16'h000D, 16'h000E}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd15, 16'd93, HostA, 16'h000F, 16'h0010,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_TOO_SHORT, 16'h000F, 16'h0010}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd15, 16'hFFFF, HostA, 16'h0011, 16'h0012,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NO_FLOW, 16'h0011, 16'h0012}},
    '{'{1'b1, 16'h0, 8'h0, 4'd0, 16'd0, HostA, 16'h0000, 16'h0000,
        4'd0, 1'b1, 16'h1F90, 16'hC350}, 1'b1, '{ST_ENTRY_WR, 16'h0000, 16'h0000}},
    '{'{1'b1, 16'h0, 8'h0, 4'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
        4'd15, 1'b1, 16'hFFFF, 16'h0000}, 1'b1, '{ST_ENTRY_WR, 16'hFFFF, 16'hFFFF}},
    '{'{1'b1, 16'h0, 8'h0, 4'd0, 16'd0, HostB, 16'hAAAA, 16'h5555,
        4'd3, 1'b0, 16'h0001, 16'h0002}, 1'b1, '{ST_ENTRY_WR, 16'hAAAA, 16'h5555}},
    // second entry for HostA at a higher slot
    '{'{1'b1, 16'h0, 8'h0, 4'd0, 16'd0, HostA, 16'h5555, 16'hAAAA,
        4'd7, 1'b1, 16'h1111, 16'h2222}, 1'b1, '{ST_ENTRY_WR, 16'h5555, 16'hAAAA}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd54, HostA, 16'hC350, 16'hB1E6,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b0, '0},
    // lowest slot wins, so its redirected port decides
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd54, HostA, 16'h2222, 16'h4321,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_PORT_MISS, 16'h2222, 16'h4321}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd54, HostB, 16'h0002, 16'h0BAD,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_NO_FLOW, 16'h0002, 16'h0BAD}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd54, 32'hFFFF_FFFF, 16'h0000, 16'h0000,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd5, 16'd54, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{1'b1, 16'h0, 8'h0, 4'd0, 16'd0, HostA, 16'h0101, 16'h0202,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b1, '{ST_ENTRY_WR, 16'h0101, 16'h0202}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd15, 16'd94, HostA, 16'h2222, 16'h1234,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{1'b1, 16'hFFFF, 8'hFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
        4'hF, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_ENTRY_WR, 16'hFFFF, 16'hFFFF}},
    '{'{1'b0, EthPIp, IpProtoTcp, 4'd0, 16'd34, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
        4'd0, 1'b0, 16'h0, 16'h0}, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] source_port_out_o;
  logic [15:0] checksum_out_o;

  hdr_item_t   drv_item = '0;
  logic        drv_typed = 1'b0;
  hdr_result_t drv_typed_res = '0;
  logic        steady = 1'b0;

  // predictor copy of the flow table
  logic        flow_valid [FlowEntries] = '{default: 1'b0};
  logic [31:0] flow_key   [FlowEntries] = '{default: 32'h0};
  logic [15:0] flow_orig  [FlowEntries] = '{default: 16'h0};
  logic [15:0] flow_redir [FlowEntries] = '{default: 16'h0};

  logic [31:0] host_pool [6];
  logic [15:0] port_pool [4];

  hdr_result_t pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  always #1 clk_i = ~clk_i;

  tcp_source_port_restore i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .mode_i                 (drv_item.mode),
    .ether_type_i           (drv_item.ether_type),
    .ip_protocol_i          (drv_item.ip_protocol),
    .ip_header_words_i      (drv_item.ip_header_words),
    .frame_length_i         (drv_item.frame_length),
    .dest_ip_i              (drv_item.dest_ip),
    .tcp_source_port_i      (drv_item.tcp_source_port),
    .tcp_checksum_i         (drv_item.tcp_checksum),
    .entry_index_i          (drv_item.entry_index),
    .entry_valid_i          (drv_item.entry_valid),
    .entry_original_port_i  (drv_item.entry_original_port),
    .entry_redirected_port_i(drv_item.entry_redirected_port),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .status_o               (status_o),
    .source_port_out_o      (source_port_out_o),
    .checksum_out_o         (checksum_out_o)
  );

  function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // lowest valid slot whose key matches, -1 if none
  function automatic int first_flow(input logic [31:0] dip);
    for (int e = 0; e < FlowEntries; e++) begin
      if (flow_valid[e] && flow_key[e] == dip) return e;
    end
    return -1;
  endfunction

  function automatic hdr_result_t restore_port(input hdr_item_t it);
    hdr_result_t r;
    int          hit;
    int          flen;
    logic [15:0] acc;
    r.status      = ST_ENTRY_WR;
    r.source_port = it.tcp_source_port;
    r.checksum    = it.tcp_checksum;
    flen          = int'(it.frame_length);
    if (it.mode) begin
      if (int'(it.entry_index) < FlowEntries) begin
        flow_valid[it.entry_index] = it.entry_valid;
        flow_key[it.entry_index]   = it.dest_ip;
        flow_orig[it.entry_index]  = it.entry_original_port;
        flow_redir[it.entry_index] = it.entry_redirected_port;
      end
    end else if (flen < int'(MinEthLen)) begin
      r.status = ST_TOO_SHORT;
    end else if (it.ether_type != EthPIp) begin
      r.status = ST_NOT_IPV4;
    end else if (flen < int'(MinIpLen)) begin
      r.status = ST_TOO_SHORT;
    end else if (it.ip_protocol != IpProtoTcp) begin
      r.status = ST_NOT_TCP;
    end else if (flen < int'(MinIpLen) + 4 * int'(it.ip_header_words)) begin
      r.status = ST_TOO_SHORT;
    end else begin
      hit = first_flow(it.dest_ip);
      if (hit < 0) begin
        r.status = ST_NO_FLOW;
      end else if (it.tcp_source_port != flow_redir[hit]) begin
        r.status = ST_PORT_MISS;
      end else begin
        // HC' = ~(~HC + ~m + m')
        acc = ones_sum(~it.tcp_checksum, ~it.tcp_source_port);
        acc = ones_sum(acc, flow_orig[hit]);
        r.status      = ST_REWRITTEN;
        r.source_port = flow_orig[hit];
        r.checksum    = ~acc;
      end
    end
    return r;
  endfunction

  // mostly well-formed TCP headers aimed at known hosts, some table writes, some noise
  function automatic hdr_item_t random_header();
    hdr_item_t    it;
    logic [159:0] bits;
    int           kind;
    int           hit;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it   = bits[145:0];
    kind = $urandom_range(99);
    if (kind < 15) return it;
    it.dest_ip = host_pool[$urandom_range(5)];
    if (kind < 35) begin
      it.mode                  = 1'b1;
      it.entry_valid           = ($urandom_range(9) != 0);
      it.entry_redirected_port = port_pool[$urandom_range(3)];
    end else begin
      it.mode            = 1'b0;
      it.ether_type      = EthPIp;
      it.ip_protocol     = IpProtoTcp;
      it.ip_header_words = 4'($urandom_range(15));
      it.frame_length    = 16'(int'(MinIpLen) + 4 * int'(it.ip_header_words)
                               + $urandom_range(1400));
      if ($urandom_range(9) == 0)
        it.frame_length = 16'(int'(MinIpLen) + 4 * int'(it.ip_header_words)
                              - $urandom_range(1));
      hit = first_flow(it.dest_ip);
      if (hit >= 0 && $urandom_range(9) < 7)
        it.tcp_source_port = flow_redir[hit];
      else if ($urandom_range(1) == 0)
        it.tcp_source_port = port_pool[$urandom_range(3)];
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PrintCap)
      $display("mismatch on %s: got %0h, expected %0h at cycle %0d",
               what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic send_header(input hdr_item_t it, input logic typed, input hdr_result_t res);
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    in_valid_i    <= 1'b1;
    drv_item      <= it;
    drv_typed     <= typed;
    drv_typed_res <= res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < IdlePct);

  // result check first, then record the beat accepted at this edge
  always @(posedge clk_i) begin
    hdr_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", {29'd0, status_o}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", {29'd0, status_o}, {29'd0, want.status});
        if (source_port_out_o != want.source_port)
          report_mismatch("source port", {16'd0, source_port_out_o}, {16'd0, want.source_port});
        if (checksum_out_o != want.checksum)
          report_mismatch("checksum", {16'd0, checksum_out_o}, {16'd0, want.checksum});
      end
    end
    if (in_valid_i && !in_stall_o) begin
      want = restore_port(drv_item);
      if (drv_typed) want = drv_typed_res;
      pending_results.push_back(want);
    end
  end

  initial begin
    foreach (host_pool[h]) host_pool[h] = $urandom;
    foreach (port_pool[p]) port_pool[p] = 16'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) send_header(DirRows[r].item, DirRows[r].typed, DirRows[r].res);

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 150 && n < 300);
      if (n == 400) begin
        // drain the block completely before going on
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      send_header(random_header(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (FlowEntries + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
